// ===== rtl/plst_pkg.sv =====
package plst_pkg;

  // Number of words the list can hold.
  localparam int CAPACITY = 16;

  // Storage index and occupancy widths follow from the capacity.
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Payload field widths.
  localparam int FUNC_W   = 2;
  localparam int POS_W    = 5;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 5;

  // Width used to compare a request position against the occupancy.
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Packed stream words, rounded up to whole bytes.
  localparam int IN_BITS   = FUNC_W + POS_W + WORD_W;
  localparam int OUT_BITS  = STATUS_W + WORD_W + LEN_W + 1;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Operation codes.
  localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] OP_READ   = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] STS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_PRIME,
    S_INS_MOVE,
    S_INS_PUT,
    S_REM_PRIME,
    S_REM_MOVE,
    S_RD_CAP,
    S_FINISH
  } state_t;

endpackage

// ===== rtl/plst_ram.sv =====
module plst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

// ===== rtl/positional_list_store.sv =====
// A refused request goes straight to the finish state; a read passes through a capture state.
// An insert before the tail primes a read, shifts the words at and above the position up one
// place, then writes the new word; an append writes it directly. A remove moves the words above
// the removed one down one place; removing the last word moves nothing. Only one request at
// a time: the next beat is taken once the result is registered, which waits while an earlier
// result is held back. Reset (rst_n low, synchronous) empties the list and the result.
module positional_list_store (
  input  logic                               clk,
  input  logic                               rst_n,
  // Request channel.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // From bit 0: func[1:0], position[6:2], value[38:7], zero pad[39].
  input  logic [plst_pkg::IN_DATA_W-1:0]     in_tdata,
  // Result channel.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // From bit 0: status[1:0], read_value[33:2], length[38:34], is_empty[39].
  output logic [plst_pkg::OUT_DATA_W-1:0]    out_tdata
);

  localparam int IDX_W = plst_pkg::IDX_W;
  localparam int CNT_W = plst_pkg::CNT_W;
  localparam int CMP_W = plst_pkg::CMP_W;

  // Unpack the request beat.
  logic [plst_pkg::FUNC_W-1:0] in_func;
  logic [plst_pkg::POS_W-1:0]  in_position;
  logic [plst_pkg::WORD_W-1:0] in_value;

  assign in_func     = in_tdata[1:0];
  assign in_position = in_tdata[6:2];
  assign in_value    = in_tdata[38:7];

  // Sequencer and datapath registers.
  plst_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [IDX_W-1:0]              ptr_r, ptr_nxt;
  logic [IDX_W-1:0]              pos_r, pos_nxt;
  logic [plst_pkg::WORD_W-1:0]   value_r, value_nxt;
  logic [plst_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [plst_pkg::WORD_W-1:0]   rdv_r, rdv_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [plst_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Word memory ports.
  logic                        ram_wr_en;
  logic [IDX_W-1:0]            ram_wr_addr;
  logic [plst_pkg::WORD_W-1:0] ram_wr_data;
  logic [IDX_W-1:0]            ram_rd_addr;
  logic [plst_pkg::WORD_W-1:0] ram_rd_data;

  plst_ram #(
    .WIDTH (plst_pkg::WORD_W),
    .DEPTH (plst_pkg::CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Request decode. The position is checked before the room on an insert.
  logic             accept;
  logic [CMP_W-1:0] pos_cmp;
  logic [CMP_W-1:0] cnt_cmp;
  logic             pos_le_cnt;
  logic             pos_lt_cnt;
  logic             list_full;
  logic             ins_shift;
  logic             rem_shift;
  logic [IDX_W-1:0] pos_idx;
  logic [CNT_W-1:0] ptr_plus_one;
  logic             ins_more;
  logic             rem_more;

  assign accept     = in_tvalid && in_tready;
  assign pos_cmp    = CMP_W'(in_position);
  assign cnt_cmp    = CMP_W'(count_r);
  assign pos_le_cnt = (pos_cmp <= cnt_cmp);
  assign pos_lt_cnt = (pos_cmp < cnt_cmp);
  assign list_full  = (count_r == CNT_W'(plst_pkg::CAPACITY));
  assign pos_idx    = IDX_W'(in_position);
  // An insert moves words only when it lands before the tail.
  assign ins_shift  = pos_lt_cnt;
  // A remove moves words only when something stands above the removed word.
  assign rem_shift  = (pos_cmp + CMP_W'(1)) < cnt_cmp;

  // Loop tests while shifting. The count already holds its new value here.
  assign ptr_plus_one = CNT_W'(ptr_r) + CNT_W'(1);
  assign ins_more     = (ptr_r - IDX_W'(1)) > pos_r;
  assign rem_more     = ptr_plus_one < count_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      plst_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = plst_pkg::S_FINISH;
          case (in_func)
            plst_pkg::OP_INSERT: begin
              if (pos_le_cnt && !list_full) begin
                state_nxt = ins_shift ? plst_pkg::S_INS_PRIME : plst_pkg::S_INS_PUT;
              end
            end
            plst_pkg::OP_REMOVE: begin
              if (pos_lt_cnt && rem_shift) begin
                state_nxt = plst_pkg::S_REM_PRIME;
              end
            end
            plst_pkg::OP_READ: begin
              if (pos_lt_cnt) begin
                state_nxt = plst_pkg::S_RD_CAP;
              end
            end
            default: state_nxt = plst_pkg::S_FINISH;
          endcase
        end
      end
      plst_pkg::S_INS_PRIME: state_nxt = plst_pkg::S_INS_MOVE;
      plst_pkg::S_INS_MOVE: begin
        if (!ins_more) begin
          state_nxt = plst_pkg::S_INS_PUT;
        end
      end
      plst_pkg::S_INS_PUT:   state_nxt = plst_pkg::S_FINISH;
      plst_pkg::S_REM_PRIME: state_nxt = plst_pkg::S_REM_MOVE;
      plst_pkg::S_REM_MOVE: begin
        if (!rem_more) begin
          state_nxt = plst_pkg::S_FINISH;
        end
      end
      plst_pkg::S_RD_CAP: state_nxt = plst_pkg::S_FINISH;
      plst_pkg::S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = plst_pkg::S_IDLE;
        end
      end
      default: state_nxt = plst_pkg::S_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    in_tready     = (state_r == plst_pkg::S_IDLE);
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    pos_nxt       = pos_r;
    value_nxt     = value_r;
    status_nxt    = status_r;
    rdv_nxt       = rdv_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = ptr_r;
    ram_wr_data   = ram_rd_data;
    ram_rd_addr   = ptr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    case (state_r)
      plst_pkg::S_IDLE: begin
        // A read of the addressed word is issued speculatively every idle cycle.
        ram_rd_addr = pos_idx;
        if (accept) begin
          status_nxt = plst_pkg::STS_RANGE;
          rdv_nxt    = '0;
          pos_nxt    = pos_idx;
          value_nxt  = in_value;
          case (in_func)
            plst_pkg::OP_INSERT: begin
              if (pos_le_cnt) begin
                if (list_full) begin
                  status_nxt = plst_pkg::STS_FULL;
                end else begin
                  status_nxt = plst_pkg::STS_DONE;
                  count_nxt  = count_r + CNT_W'(1);
                  ptr_nxt    = IDX_W'(count_r);
                end
              end
            end
            plst_pkg::OP_REMOVE: begin
              if (pos_lt_cnt) begin
                status_nxt = plst_pkg::STS_DONE;
                count_nxt  = count_r - CNT_W'(1);
                ptr_nxt    = pos_idx;
              end
            end
            plst_pkg::OP_READ: begin
              if (pos_lt_cnt) begin
                status_nxt = plst_pkg::STS_DONE;
              end
            end
            default: status_nxt = plst_pkg::STS_RANGE;
          endcase
        end
      end
      plst_pkg::S_INS_PRIME: begin
        ram_rd_addr = ptr_r - IDX_W'(1);
      end
      plst_pkg::S_INS_MOVE: begin
        // Word fetched last cycle from ptr - 1 lands one place up.
        ram_wr_en   = 1'b1;
        ram_wr_addr = ptr_r;
        ram_rd_addr = ptr_r - IDX_W'(2);
        if (ins_more) begin
          ptr_nxt = ptr_r - IDX_W'(1);
        end
      end
      plst_pkg::S_INS_PUT: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = pos_r;
        ram_wr_data = value_r;
      end
      plst_pkg::S_REM_PRIME: begin
        ram_rd_addr = ptr_r + IDX_W'(1);
      end
      plst_pkg::S_REM_MOVE: begin
        // Word fetched last cycle from ptr + 1 lands one place down.
        ram_wr_en   = 1'b1;
        ram_wr_addr = ptr_r;
        ram_rd_addr = ptr_r + IDX_W'(2);
        if (rem_more) begin
          ptr_nxt = ptr_r + IDX_W'(1);
        end
      end
      plst_pkg::S_RD_CAP: begin
        rdv_nxt = ram_rd_data;
      end
      plst_pkg::S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt[1:0]   = status_r;
          out_data_nxt[33:2]  = rdv_r;
          out_data_nxt[38:34] = plst_pkg::LEN_W'(count_r);
          out_data_nxt[39]    = (count_r == '0);
        end
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plst_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    pos_r      <= pos_nxt;
    value_r    <= value_nxt;
    status_r   <= status_nxt;
    rdv_r      <= rdv_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/plst_checker.sv =====
module plst_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [plst_pkg::OUT_DATA_W-1:0] out_tdata
);

  // A result beat that is held back keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // The sequencer is busy in the cycle after taking a request.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken in consecutive cycles");

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] == plst_pkg::STS_DONE) ||
                   (out_tdata[1:0] == plst_pkg::STS_RANGE) ||
                   (out_tdata[1:0] == plst_pkg::STS_FULL))
    else $error("undefined status code");

  // A refused request never carries read data.
  a_refused_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != plst_pkg::STS_DONE) |-> (out_tdata[33:2] == '0))
    else $error("refused request returned data");

  // A full status is only ever given with a full list.
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == plst_pkg::STS_FULL) |->
      (out_tdata[38:34] == plst_pkg::LEN_W'(plst_pkg::CAPACITY)))
    else $error("full status with room left");

endmodule

bind positional_list_store plst_checker u_plst_checker (.*);
